// File: rtl/tqbrrm_pkg.sv
// Package for the three-queue burst round-robin merge.
// Holds command/result beat types, opcodes and default sizes.
// No dependencies.
package tqbrrm_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 128;
  localparam int unsigned NUM_QUEUES_DEF  = 3;

  localparam int unsigned SEL_W   = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned BURST_W = 4;

  localparam logic [BURST_W-1:0] BURST_LEN_RST = 4'd3;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef struct packed {
    action_e                   action;
    logic [SEL_W-1:0]          queue_sel;
    logic signed [DATA_W-1:0]  push_value;
  } cmd_t;

  typedef struct packed {
    logic                      push_accepted;
    logic                      pop_valid;
    logic signed [DATA_W-1:0]  pop_value;
    logic [SEL_W-1:0]          pop_source;
  } res_t;

endpackage

// File: rtl/three_queue_burst_round_robin_merge.sv
// Top level: NUM_QUEUES circular FIFOs sharing one storage array,
// merged under burst round-robin. Depends on tqbrrm_pkg.
//
//  channel   direction  handshake                 beat
//  command   in         start && !busy            cmd_i (tqbrrm_pkg::cmd_t)
//  result    out        done_o, one cycle         res_o (tqbrrm_pkg::res_t)
//  config    in         cfg_valid_i && cfg_ready_o cfg_data_i (burst_len)
//
// One command per cycle; busy is always low. The result beat appears in the
// cycle after its command, as the read port of the store is registered.
// Reset clears pointers, counts and arbiter state at once; the store
// itself is not cleared, so there is no clearing pass.
// The receiver cannot stall: done_o is high for exactly one cycle.
module three_queue_burst_round_robin_merge #(
  parameter int unsigned QUEUE_DEPTH = tqbrrm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  tqbrrm_pkg::cmd_t                   cmd_i,
  output logic                               done_o,
  output tqbrrm_pkg::res_t                   res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tqbrrm_pkg::BURST_W-1:0]     cfg_data_i
);

  // queue select and source fields are sized in the package for this count
  localparam int unsigned NUM_QUEUES = tqbrrm_pkg::NUM_QUEUES_DEF;

  localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW  = (QW > tqbrrm_pkg::SEL_W) ? QW : tqbrrm_pkg::SEL_W;
  localparam int unsigned BW  = tqbrrm_pkg::BURST_W;

  logic signed [tqbrrm_pkg::DATA_W-1:0] mem [NUM_QUEUES][QUEUE_DEPTH];

  logic [PW-1:0] head_q [NUM_QUEUES];
  logic [PW-1:0] head_d [NUM_QUEUES];
  logic [CW-1:0] cnt_q  [NUM_QUEUES];
  logic [CW-1:0] cnt_d  [NUM_QUEUES];
  logic [QW-1:0] cur_q, cur_d;
  logic [BW-1:0] served_q, served_d;
  logic [BW-1:0] burst_len_q;

  logic          accept;
  logic          is_push, is_pop;
  logic [SW-1:0] sel_ext;
  logic [QW-1:0] sel_q_idx;
  logic          push_ok;
  logic [PW:0]   wr_sum;
  logic [PW-1:0] wr_slot;

  logic          found;
  logic [QW-1:0] pq;
  logic          pop_ok;
  logic [BW-1:0] lim;
  logic [BW-1:0] served_base, served_inc;
  logic [CW-1:0] cnt_left;
  logic [QW-1:0] pq_next;

  logic                                 done_q;
  logic                                 acc_q, pvalid_q;
  logic [tqbrrm_pkg::SEL_W-1:0]         psrc_q;
  logic signed [tqbrrm_pkg::DATA_W-1:0] rd_data_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign is_push     = accept && (cmd_i.action == tqbrrm_pkg::ACT_PUSH);
  assign is_pop      = accept && (cmd_i.action == tqbrrm_pkg::ACT_POP);

  // push path: slot = (head + count) mod depth, sum stays below 2*depth
  assign sel_ext   = SW'(cmd_i.queue_sel);
  assign sel_q_idx = sel_ext[QW-1:0];
  assign push_ok   = is_push && (sel_ext < SW'(NUM_QUEUES))
                     && (cnt_q[sel_q_idx] != CW'(QUEUE_DEPTH));
  assign wr_sum    = (PW+1)'(head_q[sel_q_idx]) + (PW+1)'(cnt_q[sel_q_idx]);
  assign wr_slot   = (wr_sum >= (PW+1)'(QUEUE_DEPTH))
                     ? PW'(wr_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(wr_sum);

  // first non-empty queue at or after the current one, cyclically
  always_comb begin
    logic [QW:0]   cand_sum;
    logic [QW-1:0] cand;
    found = 1'b0;
    pq    = '0;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      cand_sum = (QW+1)'(cur_q) + (QW+1)'(k);
      cand     = (cand_sum >= (QW+1)'(NUM_QUEUES))
                 ? QW'(cand_sum - (QW+1)'(NUM_QUEUES)) : QW'(cand_sum);
      if (!found && cnt_q[cand] != '0) begin
        found = 1'b1;
        pq    = cand;
      end
    end
  end

  assign pop_ok      = is_pop && found;
  assign lim         = (burst_len_q == '0) ? BW'(1) : burst_len_q;
  assign served_base = (pq != cur_q) ? '0 : served_q;
  assign served_inc  = served_base + BW'(1);
  assign cnt_left    = cnt_q[pq] - CW'(1);
  assign pq_next     = (pq == QW'(NUM_QUEUES - 1)) ? '0 : pq + QW'(1);

  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    served_d = served_q;
    if (push_ok) begin
      cnt_d[sel_q_idx] = cnt_q[sel_q_idx] + CW'(1);
    end
    if (pop_ok) begin
      head_d[pq] = (head_q[pq] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q[pq] + PW'(1);
      cnt_d[pq]  = cnt_left;
      if (served_inc >= lim || cnt_left == '0) begin
        cur_d    = pq_next;
        served_d = '0;
      end else begin
        cur_d    = pq;
        served_d = served_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      cur_q       <= '0;
      served_q    <= '0;
      burst_len_q <= tqbrrm_pkg::BURST_LEN_RST;
      done_q      <= 1'b0;
      acc_q       <= 1'b0;
      pvalid_q    <= 1'b0;
    end else begin
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      cur_q    <= cur_d;
      served_q <= served_d;
      if (cfg_valid_i && cfg_ready_o) begin
        burst_len_q <= cfg_data_i;
      end
      done_q   <= accept;
      acc_q    <= push_ok;
      pvalid_q <= pop_ok;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[sel_q_idx][wr_slot] <= cmd_i.push_value;
    end
    if (pop_ok) begin
      rd_data_q <= mem[pq][head_q[pq]];
    end
  end

  always_ff @(posedge clk_i) begin
    psrc_q <= pop_ok ? tqbrrm_pkg::SEL_W'(pq) : '0;
  end

  assign done_o              = done_q;
  assign res_o.push_accepted = acc_q;
  assign res_o.pop_valid     = pvalid_q;
  assign res_o.pop_value     = pvalid_q ? rd_data_q : '0;
  assign res_o.pop_source    = psrc_q;

  a_one_result_per_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("command beat without result beat");

  a_push_pop_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.push_accepted && res_o.pop_valid))
    else $error("result flags both push and pop");

  a_flags_need_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.push_accepted || res_o.pop_valid) |-> done_o)
    else $error("result flag outside a result beat");

  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < NUM_QUEUES)
    else $error("current queue out of range");

  a_served_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i == 1'b0 && $past(pop_ok)) |-> (served_q < lim))
    else $error("burst count reached limit without moving on");

endmodule
